[design/pts_pkg.sv]
package pts_pkg;

	localparam int MAX_TASKS = 64;
	localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);

	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_TICK  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [31:0] TIME_MAX  = 32'hFFFF_FFFF;
	localparam logic [16:0] NONE_MARK = 17'h1_0000;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] task_id;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [15:0] prio_level;
	} req_word_t;

	typedef struct packed {
		logic        load_ok;
		logic        ran;
		logic [15:0] run_id;
		logic        switched;
		logic        finished;
		logic [31:0] turnaround;
		logic [31:0] waiting;
		logic [31:0] total_turnaround;
		logic [31:0] total_waiting;
		logic [31:0] now_tick;
		logic        all_done;
	} rsp_word_t;

	// one table slot as held in the task memory
	typedef struct packed {
		logic [15:0] id;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [15:0] prio;
		logic [15:0] remaining;
	} entry_t;

	typedef struct packed {
		logic latch;
		logic rd_en;
		logic calc;
		logic settle;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic req_is_tick;
		logic table_empty;
		logic scan_last;
		logic rsp_free;
	} stat_t;

endpackage

[design/pts_ctrl.sv]
module pts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  pts_pkg::stat_t stat,
	output pts_pkg::cmd_t  cmd
);
	import pts_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_CALC,
		ST_SETTLE,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   stall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stall_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						stall_q <= 1'b1;
						if (!stat.req_is_tick) begin
							state_q <= ST_COMMIT;
						end else if (stat.table_empty) begin
							state_q <= ST_CALC;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (stat.scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN:  state_q <= ST_CALC;
				ST_CALC:   state_q <= ST_SETTLE;
				ST_SETTLE: state_q <= ST_COMMIT;
				ST_COMMIT: begin
					if (stat.rsp_free) begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

	assign req_stall = stall_q;

	always_comb begin
		cmd        = '0;
		cmd.latch  = (state_q == ST_IDLE) && req_valid;
		cmd.rd_en  = (state_q == ST_SCAN);
		cmd.calc   = (state_q == ST_CALC);
		cmd.settle = (state_q == ST_SETTLE);
		cmd.commit = (state_q == ST_COMMIT) && stat.rsp_free;
	end

endmodule

[design/pts_datapath.sv]
module pts_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  pts_pkg::cmd_t      cmd,
	output pts_pkg::stat_t     stat,
	input  pts_pkg::req_word_t req_word,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output pts_pkg::rsp_word_t rsp_word
);
	import pts_pkg::*;

	entry_t task_mem [MAX_TASKS];
	entry_t rd_q;

	req_word_t            req_q;
	logic [SLOT_W-1:0]    rd_addr_q;
	logic                 rd_vld_s1;
	logic [SLOT_W-1:0]    rd_slot_s1;
	logic                 found_q;
	entry_t               best_q;
	logic [SLOT_W-1:0]    best_slot_q;
	logic [MAX_TASKS-1:0] done_q;
	logic [CNT_W-1:0]     loaded_q;
	logic [CNT_W-1:0]     finished_q;
	logic [31:0]          time_q;
	logic [31:0]          tnext_q;
	logic [16:0]          last_id_q;
	logic [31:0]          sum_turn_q;
	logic [31:0]          sum_wait_q;
	logic [15:0]          rem_new_q;
	logic [31:0]          turn_q;
	logic [31:0]          wait_q;
	logic                 rsp_valid_q;
	rsp_word_t            rsp_q;

	logic                 eligible;
	logic                 better;
	logic                 take;
	logic                 load_ok;
	logic                 mem_we;
	logic [SLOT_W-1:0]    mem_wa;
	entry_t               mem_wd;
	logic [32:0]          sum_turn_add;
	logic [32:0]          sum_wait_add;

	logic [CNT_W-1:0]     loaded_n;
	logic [CNT_W-1:0]     finished_n;
	logic [31:0]          time_n;
	logic [16:0]          last_n;
	logic [31:0]          sum_turn_n;
	logic [31:0]          sum_wait_n;
	logic [MAX_TASKS-1:0] done_n;
	rsp_word_t            rsp_n;

	// status toward the controller
	always_comb begin
		stat             = '0;
		stat.req_is_tick = (req_word.req_type == REQ_TICK);
		stat.table_empty = (loaded_q == '0);
		stat.scan_last   = (CNT_W'(rd_addr_q) == (loaded_q - CNT_W'(1)));
		stat.rsp_free    = !rsp_valid_q || !rsp_stall;
	end

	// scan compare: later slot wins a full tie since the scan runs upward
	assign eligible = !done_q[rd_slot_s1] && ({16'b0, rd_q.arrival} <= time_q);
	assign better   = !found_q || (rd_q.prio < best_q.prio) ||
		((rd_q.prio == best_q.prio) && (rd_q.arrival <= best_q.arrival));
	assign take     = rd_vld_s1 && eligible && better;

	assign load_ok = (req_q.req_type == REQ_LOAD) && (loaded_q < CNT_W'(MAX_TASKS)) &&
		(req_q.burst != 16'd0);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = best_slot_q;
		mem_wd = best_q;
		mem_wd.remaining = rem_new_q;
		if (cmd.commit && load_ok) begin
			mem_we           = 1'b1;
			mem_wa           = loaded_q[SLOT_W-1:0];
			mem_wd.id        = req_q.task_id;
			mem_wd.arrival   = req_q.arrival;
			mem_wd.burst     = req_q.burst;
			mem_wd.prio      = req_q.prio_level;
			mem_wd.remaining = req_q.burst;
		end else if (cmd.commit && (req_q.req_type == REQ_TICK) && found_q) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			task_mem[mem_wa] <= mem_wd;
		end
		rd_q <= task_mem[rd_addr_q];
	end

	assign sum_turn_add = {1'b0, sum_turn_q} + {1'b0, turn_q};
	assign sum_wait_add = {1'b0, sum_wait_q} + {1'b0, wait_q};

	// state after the item, taken on commit
	always_comb begin
		loaded_n   = loaded_q;
		finished_n = finished_q;
		time_n     = time_q;
		last_n     = last_id_q;
		sum_turn_n = sum_turn_q;
		sum_wait_n = sum_wait_q;
		done_n     = done_q;
		rsp_n      = '0;
		case (req_q.req_type)
			REQ_LOAD: begin
				if (load_ok) begin
					loaded_n = loaded_q + CNT_W'(1);
					done_n[loaded_q[SLOT_W-1:0]] = 1'b0;
					rsp_n.load_ok = 1'b1;
				end
			end
			REQ_TICK: begin
				time_n = tnext_q;
				if (found_q) begin
					rsp_n.ran    = 1'b1;
					rsp_n.run_id = best_q.id;
					if ({1'b0, best_q.id} != last_id_q) begin
						rsp_n.switched = 1'b1;
						last_n         = {1'b0, best_q.id};
					end
					if (rem_new_q == 16'd0) begin
						rsp_n.finished   = 1'b1;
						rsp_n.turnaround = turn_q;
						rsp_n.waiting    = wait_q;
						sum_turn_n = sum_turn_add[32] ? TIME_MAX : sum_turn_add[31:0];
						sum_wait_n = sum_wait_add[32] ? TIME_MAX : sum_wait_add[31:0];
						done_n[best_slot_q] = 1'b1;
						finished_n = finished_q + CNT_W'(1);
					end
				end
			end
			REQ_CLEAR: begin
				loaded_n   = '0;
				finished_n = '0;
				time_n     = '0;
				last_n     = NONE_MARK;
				sum_turn_n = '0;
				sum_wait_n = '0;
				done_n     = '0;
			end
			default: ;
		endcase
		rsp_n.total_turnaround = sum_turn_n;
		rsp_n.total_waiting    = sum_wait_n;
		rsp_n.now_tick         = time_n;
		rsp_n.all_done         = (finished_n == loaded_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			done_q      <= '0;
			loaded_q    <= '0;
			finished_q  <= '0;
			time_q      <= '0;
			last_id_q   <= NONE_MARK;
			sum_turn_q  <= '0;
			sum_wait_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.latch) begin
				found_q <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end
			if (cmd.commit) begin
				done_q      <= done_n;
				loaded_q    <= loaded_n;
				finished_q  <= finished_n;
				time_q      <= time_n;
				last_id_q   <= last_n;
				sum_turn_q  <= sum_turn_n;
				sum_wait_q  <= sum_wait_n;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tnext_q <= (time_q == TIME_MAX) ? time_q : time_q + 32'd1;
		if (cmd.latch) begin
			req_q     <= req_word;
			rd_addr_q <= '0;
		end else if (cmd.rd_en) begin
			rd_addr_q <= rd_addr_q + SLOT_W'(1);
		end
		rd_slot_s1 <= rd_addr_q;
		if (take) begin
			best_q      <= rd_q;
			best_slot_q <= rd_slot_s1;
		end
		if (cmd.calc) begin
			rem_new_q <= best_q.remaining - 16'd1;
			turn_q    <= tnext_q - {16'b0, best_q.arrival};
		end
		if (cmd.settle) begin
			wait_q <= (turn_q >= {16'b0, best_q.burst}) ?
				(turn_q - {16'b0, best_q.burst}) : 32'd0;
		end
		if (cmd.commit) begin
			rsp_q <= rsp_n;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	a_fin_le_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q <= loaded_q)
		else $error("finished count above loaded count");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!rsp_valid_q || !rsp_stall))
		else $error("result word overwritten while stalled");

	a_rise_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(cmd.commit))
		else $error("result valid without commit");

	a_fin_ran: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.finished) |-> (rsp_q.ran && !rsp_q.load_ok))
		else $error("completion reported without a running task");

endmodule

[design/preemptive_priority_tick_scheduler_top.sv]
// Preemptive priority tick scheduler. Each request word is a task load, a
// one-tick advance or a clear, and each gives exactly one result word. A load,
// clear or unused request goes straight from acceptance to the commit state. A
// tick scans the loaded tasks, one slot per cycle, from a task table that sits
// in one memory with a single registered read port; then the drain, calc, settle
// and commit states work out turnaround, waiting and the saturating totals. An
// empty table skips the scan and the drain. A result waits in an output
// register and the next request can be taken while it is stalled; a later
// result is held back until that register is free. No clearing pass is needed
// after reset.
module preemptive_priority_tick_scheduler_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  pts_pkg::req_word_t req_word,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output pts_pkg::rsp_word_t rsp_word
);
	import pts_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	pts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	pts_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word)
	);

endmodule

[sim/preemptive_priority_tick_scheduler_top_tb.sv]
`timescale 1ns / 100ps

module preemptive_priority_tick_scheduler_top_tb;

	import pts_pkg::*;

	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int TAIL_CYCLES = 100;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_PRINTS  = 50;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_word_t req_word = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp_word;

	// scheduler state as predicted
	logic [15:0] slot_id      [MAX_TASKS];
	logic [15:0] slot_arrival [MAX_TASKS];
	logic [15:0] slot_burst   [MAX_TASKS];
	logic [15:0] slot_prio    [MAX_TASKS];
	logic [15:0] slot_left    [MAX_TASKS];
	bit          slot_done    [MAX_TASKS];
	int unsigned tasks_loaded;
	int unsigned tasks_done;
	logic [31:0] sched_time;
	logic [16:0] prev_run_id;
	logic [31:0] turn_total;
	logic [31:0] wait_total;

	rsp_word_t pending_results [$];

	int items_sent;
	int results_seen;
	int error_count;
	int n_ran;
	int n_completed;
	int n_refused;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	bit hold_req = 1'b0;
	logic rx_hold;

	preemptive_priority_tick_scheduler_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word)
	);

	always #2 clk = ~clk;

	function automatic void clear_sched();
		tasks_loaded = 0;
		tasks_done = 0;
		sched_time = '0;
		prev_run_id = NONE_MARK;
		turn_total = '0;
		wait_total = '0;
		for (int i = 0; i < MAX_TASKS; i++) begin
			slot_done[i] = 1'b0;
		end
	endfunction

	function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? '1 : s[31:0];
	endfunction

	function automatic rsp_word_t schedule_step(input req_word_t w);
		rsp_word_t r;
		int i;
		int best;
		bit found;
		logic [31:0] turn;
		logic [31:0] wait_t;
		r = '0;
		best = 0;
		found = 1'b0;
		case (w.req_type)
			REQ_LOAD: begin
				if (tasks_loaded < MAX_TASKS && w.burst != 16'd0) begin
					slot_id[tasks_loaded] = w.task_id;
					slot_arrival[tasks_loaded] = w.arrival;
					slot_burst[tasks_loaded] = w.burst;
					slot_prio[tasks_loaded] = w.prio_level;
					slot_left[tasks_loaded] = w.burst;
					slot_done[tasks_loaded] = 1'b0;
					tasks_loaded++;
					r.load_ok = 1'b1;
				end else begin
					n_refused++;
				end
			end
			REQ_TICK: begin
				for (i = 0; i < tasks_loaded; i++) begin
					if (!slot_done[i] && {16'd0, slot_arrival[i]} <= sched_time) begin
						// equal priority: earlier arrival, then the later slot
						if (!found || slot_prio[i] < slot_prio[best] ||
						    (slot_prio[i] == slot_prio[best] &&
						     slot_arrival[i] <= slot_arrival[best])) begin
							best = i;
							found = 1'b1;
						end
					end
				end
				if (sched_time != TIME_MAX)
					sched_time++;
				if (found) begin
					n_ran++;
					r.ran = 1'b1;
					r.run_id = slot_id[best];
					if ({1'b0, slot_id[best]} != prev_run_id) begin
						r.switched = 1'b1;
						prev_run_id = {1'b0, slot_id[best]};
					end
					slot_left[best]--;
					if (slot_left[best] == 16'd0) begin
						turn = sched_time - {16'd0, slot_arrival[best]};
						wait_t = (turn >= {16'd0, slot_burst[best]}) ?
							turn - {16'd0, slot_burst[best]} : '0;
						r.finished = 1'b1;
						r.turnaround = turn;
						r.waiting = wait_t;
						turn_total = sat_sum(turn_total, turn);
						wait_total = sat_sum(wait_total, wait_t);
						slot_done[best] = 1'b1;
						tasks_done++;
						n_completed++;
					end
				end
			end
			REQ_CLEAR: begin
				clear_sched();
			end
			default: begin
			end
		endcase
		r.total_turnaround = turn_total;
		r.total_waiting = wait_total;
		r.now_tick = sched_time;
		r.all_done = (tasks_done == tasks_loaded);
		return r;
	endfunction

	function automatic req_word_t load_word(input logic [15:0] id, input logic [15:0] arr,
			input logic [15:0] len, input logic [15:0] prio);
		req_word_t w;
		w.req_type = REQ_LOAD;
		w.task_id = id;
		w.arrival = arr;
		w.burst = len;
		w.prio_level = prio;
		return w;
	endfunction

	// non-load words carry random junk in the task fields
	function automatic req_word_t op_word(input logic [1:0] op);
		req_word_t w;
		w.req_type = op;
		w.task_id = 16'($urandom_range(0, 65535));
		w.arrival = 16'($urandom_range(0, 65535));
		w.burst = 16'($urandom_range(0, 65535));
		w.prio_level = 16'($urandom_range(0, 65535));
		return w;
	endfunction

	function automatic req_word_t noise_word();
		req_word_t w;
		w = op_word(2'($urandom_range(0, 3)));
		if ($urandom_range(0, 2) == 0)
			w.burst = 16'd0;
		return w;
	endfunction

	// small id pool so different tasks can share an id
	function automatic logic [15:0] pick_id();
		return $urandom_range(0, 1) ? 16'($urandom_range(0, 7)) : 16'($urandom_range(0, 65535));
	endfunction

	task automatic send_word(input req_word_t w);
		int gap;
		gap = tx_idle ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_word <= w;
		do @(posedge clk); while (req_stall);
		pending_results.push_back(schedule_step(w));
		items_sent++;
	endtask

	task automatic wait_all_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("%t result %0d: %s got %0h expected %0h", $realtime, results_seen, what,
				got, want);
	endtask

	task automatic compare_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	task automatic check_result(input rsp_word_t got);
		rsp_word_t want;
		results_seen++;
		if (pending_results.size() == 0) begin
			report_mismatch("unexpected word, now_tick", got.now_tick, '0);
		end else begin
			want = pending_results.pop_front();
			compare_field("load_ok", got.load_ok, want.load_ok);
			compare_field("ran", got.ran, want.ran);
			compare_field("run_id", got.run_id, want.run_id);
			compare_field("switched", got.switched, want.switched);
			compare_field("finished", got.finished, want.finished);
			compare_field("turnaround", got.turnaround, want.turnaround);
			compare_field("waiting", got.waiting, want.waiting);
			compare_field("total_turnaround", got.total_turnaround, want.total_turnaround);
			compare_field("total_waiting", got.total_waiting, want.total_waiting);
			compare_field("now_tick", got.now_tick, want.now_tick);
			compare_field("all_done", got.all_done, want.all_done);
		end
	endtask

	// result side: random stall after each word, plus the long hold-off
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				check_result(rsp_word);
				if (rx_idle)
					stall_left = $urandom_range(0, 19);
			end
			rsp_stall <= rx_hold || (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	initial begin
		rx_hold <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rx_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
		end
	end

	initial begin
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("[preemptive_priority_tick_scheduler_top] ERROR");
		$finish;
	end

	task automatic test_empty_table();
		send_word(op_word(REQ_TICK));
		send_word(op_word(REQ_UNUSED));
		send_word(load_word(16'h0042, 16'd0, 16'd0, 16'd1));
	endtask

	task automatic test_priority_order();
		send_word(op_word(REQ_CLEAR));
		send_word(load_word(16'h0000, 16'd0, 16'd2, 16'hFFFF));
		send_word(load_word(16'hFFFF, 16'd1, 16'd1, 16'd0));
		// same priority and arrival as the one before: later slot wins
		send_word(load_word(16'h1234, 16'd1, 16'd1, 16'd0));
		// same priority, earlier arrival
		send_word(load_word(16'h00AA, 16'd0, 16'd1, 16'd0));
		repeat (6) send_word(op_word(REQ_TICK));
	endtask

	task automatic test_field_extremes();
		send_word(op_word(REQ_CLEAR));
		send_word(load_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_word(load_word(16'h0000, 16'h0000, 16'h0001, 16'h8000));
		send_word(op_word(REQ_TICK));
		send_word(op_word(REQ_TICK));
		send_word(op_word(REQ_CLEAR));
	endtask

	task automatic test_table_full();
		send_word(op_word(REQ_CLEAR));
		repeat (MAX_TASKS + 1)
			send_word(load_word(pick_id(), 16'($urandom_range(0, 20)),
				16'($urandom_range(1, 3)), 16'($urandom_range(0, 65535))));
		send_word(load_word(pick_id(), 16'd0, 16'd0, 16'd0));
		repeat (20) send_word(op_word(REQ_TICK));
	endtask

	task automatic run_schedule(input int n_tasks, input bit noisy);
		int ticks;
		logic [15:0] len;
		logic [15:0] prio;
		if ($urandom_range(0, 4) != 0 || sched_time > 32'd60000)
			send_word(op_word(REQ_CLEAR));
		repeat (n_tasks) begin
			if (noisy && $urandom_range(0, 9) == 0)
				send_word(noise_word());
			// ticks between loads let new arrivals preempt
			if ($urandom_range(0, 2) == 0)
				send_word(op_word(REQ_TICK));
			len = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(1, 4)) :
				16'($urandom_range(1, 12));
			prio = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 3)) :
				16'($urandom_range(0, 65535));
			send_word(load_word(pick_id(), sched_time[15:0] + 16'($urandom_range(0, 6)),
				len, prio));
		end
		ticks = 0;
		while (tasks_done != tasks_loaded && ticks < 80) begin
			if (noisy && $urandom_range(0, 15) == 0)
				send_word(noise_word());
			send_word(op_word(REQ_TICK));
			ticks++;
		end
		repeat ($urandom_range(0, 2)) send_word(op_word(REQ_TICK));
	endtask

	task automatic test_random_schedules(input int n_items);
		int goal;
		goal = items_sent + n_items;
		while (items_sent < goal) begin
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			run_schedule($urandom_range(1, 10), $urandom_range(0, 2) == 0);
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	task automatic test_output_holdoff();
		tx_idle = 1'b0;
		hold_req = 1'b1;
		send_word(op_word(REQ_CLEAR));
		repeat (4)
			send_word(load_word(pick_id(), 16'($urandom_range(0, 3)),
				16'($urandom_range(1, 6)), 16'($urandom_range(0, 3))));
		repeat (25) send_word(op_word(REQ_TICK));
		tx_idle = 1'b1;
	endtask

	task automatic test_drain_between();
		repeat (3) begin
			wait_all_results();
			run_schedule($urandom_range(2, 5), 1'b0);
		end
		wait_all_results();
	endtask

	initial begin
		clear_sched();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_priority_order();
		test_field_extremes();
		test_table_full();
		test_output_holdoff();
		test_drain_between();
		test_random_schedules(1400);

		wait_all_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d request words, %0d results: %0d ticks ran a task,",
			items_sent, results_seen, n_ran);
		$display("%0d completions, %0d refused loads", n_completed, n_refused);
		$display("covered priority ties, preemption, idle ticks, a full table,");
		$display("output hold-off and drains");
		if (error_count == 0) begin
			$display("[preemptive_priority_tick_scheduler_top] OK");
		end else begin
			$display("%0d mismatches", error_count);
			$display("[preemptive_priority_tick_scheduler_top] ERROR");
		end
		$finish;
	end

endmodule

[preemptive_priority_tick_scheduler_top.f]
design/pts_pkg.sv
design/pts_ctrl.sv
design/pts_datapath.sv
design/preemptive_priority_tick_scheduler_top.sv
sim/preemptive_priority_tick_scheduler_top_tb.sv
